/* rtl/priority_batch_scheduler_assert.svh */
// ----------------------------------------------------------------------------
// priority batch scheduler assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BATCH_SCHEDULER_ASSERT_SVH
`define PRIORITY_BATCH_SCHEDULER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define PBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen at a clock edge out of reset
`define PBS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* rtl/pbs_pkg.sv */
// ----------------------------------------------------------------------------
// pbs_pkg
// types, widths and helpers shared by the priority batch scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbs_pkg;

  localparam int MAX_TASKS = 16;

  localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 8;
  localparam int BURST_W = 16;
  localparam int ENTRY_W = ID_W + PRIO_W + BURST_W;
  localparam int ID_LSB    = 0;
  localparam int PRIO_LSB  = ID_W;
  localparam int BURST_LSB = ID_W + PRIO_W;

  localparam int FIN_W  = 20;
  localparam int AVG_W  = 28;
  localparam int FRAC_W = 8;

  // running clock and sums are exact, saturated only on the way out
  localparam int CLK_W = (BURST_W + IDX_W > FIN_W) ? BURST_W + IDX_W : FIN_W;
  localparam int SUM_W = CLK_W + IDX_W;
  localparam int DIV_W = (SUM_W + FRAC_W > AVG_W) ? SUM_W + FRAC_W : AVG_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [FIN_W-1:0] FIN_MAX = {FIN_W{1'b1}};
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

  typedef enum logic {
    FUNC_ADD,
    FUNC_RUN
  } pbs_func_t;

  typedef enum logic [1:0] {
    ST_DISPATCH,
    ST_ADDED,
    ST_FULL,
    ST_EMPTY
  } pbs_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_RUN_RD,
    S_RUN_CALC,
    S_RUN_OUT,
    S_DIV_WAIT,
    S_DIV_TURN
  } pbs_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } pbs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } pbs_div_rsp_t;

  function automatic logic [FIN_W-1:0] sat_fin(input logic [CLK_W-1:0] v);
    if (v > CLK_W'(FIN_MAX)) begin
      return FIN_MAX;
    end
    return v[FIN_W-1:0];
  endfunction

  function automatic logic [AVG_W-1:0] sat_avg(input logic [DIV_W-1:0] v);
    if (v > DIV_W'(AVG_MAX)) begin
      return AVG_MAX;
    end
    return v[AVG_W-1:0];
  endfunction

endpackage

/* rtl/pbs_if.sv */
// ----------------------------------------------------------------------------
// pbs channel interfaces
// valid/ready channels for task items in and scheduler results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pbs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [pbs_pkg::ID_W-1:0]      task_id;
  logic [pbs_pkg::PRIO_W-1:0]    task_priority;
  logic [pbs_pkg::BURST_W-1:0]   burst_length;

  modport source (output valid, func, task_id, task_priority, burst_length,
                  input ready);
  modport sink   (input valid, func, task_id, task_priority, burst_length,
                  output ready);
endinterface

interface pbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [pbs_pkg::ID_W-1:0]      out_task_id;
  logic [pbs_pkg::BURST_W-1:0]   out_burst;
  logic [pbs_pkg::FIN_W-1:0]     finish_time;
  logic [pbs_pkg::AVG_W-1:0]     avg_wait;
  logic [pbs_pkg::AVG_W-1:0]     avg_turnaround;
  logic [pbs_pkg::AVG_W-1:0]     avg_response;
  logic                          last;

  modport source (output valid, status, out_task_id, out_burst, finish_time,
                  avg_wait, avg_turnaround, avg_response, last,
                  input ready);
  modport sink   (input valid, status, out_task_id, out_burst, finish_time,
                  avg_wait, avg_turnaround, avg_response, last,
                  output ready);
endinterface

/* rtl/pbs_ram.sv */
// ----------------------------------------------------------------------------
// pbs_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pbs_div.sv */
// ----------------------------------------------------------------------------
// pbs_div
// restoring divider, one quotient bit per cycle, shared by all averages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbs_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pbs_pkg::pbs_div_req_t req,
  output pbs_pkg::pbs_div_rsp_t rsp
);

  localparam int DW = pbs_pkg::DIV_W;
  localparam int CW = pbs_pkg::CNT_W;

  logic                            busy_r;
  logic                            done_r;
  logic [pbs_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [DW-1:0]                   quo_r;
  logic [CW-1:0]                   rem_r;
  logic [CW-1:0]                   dsr_r;

  logic [CW:0] rem_sh;
  logic [CW:0] rem_sub;
  logic        q_bit;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DW-1]};
    q_bit   = (rem_sh >= {1'b0, dsr_r});
    rem_sub = q_bit ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + pbs_pkg::DIV_CNT_W'(1);
        if (cnt_r == pbs_pkg::DIV_CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], q_bit};
      rem_r <= rem_sub[CW-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* rtl/priority_batch_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_batch_scheduler
// non-preemptive priority batch: sorted task table, drain with timing stats
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  in_ch    | in  | valid/ready         | func, task_id, task_priority, burst_length
//  out_ch   | out | valid/ready         | status, ids, burst, finish, averages, last
//
//  add: the walk goes down from the tail through the single read port of the
//  task table, reading and comparing each entry, until it reaches slot zero or
//  meets an entry of equal or higher priority.
//  run: reads and emits each task in turn, waiting on out_ch; the final task
//  is emitted with last and the averages after two bit-serial divisions.
//  full and empty items answer from idle. in_ch.ready is low while busy
//  or while a result waits on out_ch. reset is synchronous; the table needs
//  no clearing pass since only the first count entries are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_batch_scheduler_assert.svh"

module priority_batch_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  pbs_in_if.sink      in_ch,
  pbs_out_if.source   out_ch
);

  localparam int IW = pbs_pkg::IDX_W;
  localparam int CW = pbs_pkg::CNT_W;
  localparam int KW = pbs_pkg::CLK_W;
  localparam int SW = pbs_pkg::SUM_W;

  pbs_pkg::pbs_state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [KW-1:0]       clock_r, clock_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [pbs_pkg::ENTRY_W-1:0] new_entry_r, new_entry_nxt;

  logic [1:0]                  status_r, status_nxt;
  logic [pbs_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [pbs_pkg::BURST_W-1:0] burst_r, burst_nxt;
  logic [pbs_pkg::FIN_W-1:0]   fin_r, fin_nxt;
  logic [pbs_pkg::AVG_W-1:0]   avg_wait_r, avg_wait_nxt;
  logic [pbs_pkg::AVG_W-1:0]   avg_turn_r, avg_turn_nxt;
  logic [pbs_pkg::AVG_W-1:0]   avg_resp_r, avg_resp_nxt;
  logic                        last_r, last_nxt;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [pbs_pkg::ENTRY_W-1:0] ram_wdata;
  logic [IW-1:0]               ram_raddr;
  logic [pbs_pkg::ENTRY_W-1:0] ram_rdata;

  pbs_pkg::pbs_div_req_t div_req;
  pbs_pkg::pbs_div_rsp_t div_rsp;

  logic                        in_fire;
  logic                        out_fire;
  logic [CW-1:0]               idx_dec;
  logic [KW-1:0]               clock_add;
  logic [SW-1:0]               sum_turn;
  logic [pbs_pkg::BURST_W-1:0] rd_burst;
  logic                        emit_short;
  pbs_pkg::pbs_status_t        emit_status;

  pbs_ram #(
    .WIDTH (pbs_pkg::ENTRY_W),
    .DEPTH (pbs_pkg::MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == pbs_pkg::S_IDLE) && !out_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  assign idx_dec   = idx_r - CW'(1);
  assign rd_burst  = ram_rdata[pbs_pkg::BURST_LSB +: pbs_pkg::BURST_W];
  assign clock_add = clock_r + KW'(rd_burst);
  assign sum_turn  = sum_r + SW'(clock_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    clock_nxt     = clock_r;
    sum_nxt       = sum_r;
    new_entry_nxt = new_entry_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    id_nxt        = id_r;
    burst_nxt     = burst_r;
    fin_nxt       = fin_r;
    avg_wait_nxt  = avg_wait_r;
    avg_turn_nxt  = avg_turn_r;
    avg_resp_nxt  = avg_resp_r;
    last_nxt      = last_r;

    ram_we    = 1'b0;
    ram_waddr = idx_r[IW-1:0];
    ram_wdata = new_entry_r;
    ram_raddr = idx_r[IW-1:0];

    div_req.start    = 1'b0;
    div_req.dividend = pbs_pkg::DIV_W'({sum_r, pbs_pkg::FRAC_W'(0)});
    div_req.divisor  = count_r;

    emit_short  = 1'b0;
    emit_status = pbs_pkg::ST_ADDED;

    case (state_r)
      pbs_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.func == pbs_pkg::FUNC_ADD) begin
            if (count_r == CW'(pbs_pkg::MAX_TASKS)) begin
              emit_short  = 1'b1;
              emit_status = pbs_pkg::ST_FULL;
            end else begin
              new_entry_nxt = {in_ch.burst_length, in_ch.task_priority, in_ch.task_id};
              idx_nxt       = count_r;
              state_nxt     = pbs_pkg::S_INS_RD;
            end
          end else if (count_r == '0) begin
            emit_short  = 1'b1;
            emit_status = pbs_pkg::ST_EMPTY;
          end else begin
            idx_nxt   = '0;
            clock_nxt = '0;
            sum_nxt   = '0;
            state_nxt = pbs_pkg::S_RUN_RD;
          end
        end
      end

      // walk down from the tail, moving lower-priority entries up one slot
      pbs_pkg::S_INS_RD: begin
        if (idx_r == '0) begin
          ram_we     = 1'b1;
          count_nxt  = count_r + CW'(1);
          emit_short = 1'b1;
          state_nxt  = pbs_pkg::S_IDLE;
        end else begin
          ram_raddr = idx_dec[IW-1:0];
          state_nxt = pbs_pkg::S_INS_CMP;
        end
      end

      pbs_pkg::S_INS_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata[pbs_pkg::PRIO_LSB +: pbs_pkg::PRIO_W] <
            new_entry_r[pbs_pkg::PRIO_LSB +: pbs_pkg::PRIO_W]) begin
          ram_wdata = ram_rdata;
          idx_nxt   = idx_dec;
          state_nxt = pbs_pkg::S_INS_RD;
        end else begin
          count_nxt  = count_r + CW'(1);
          emit_short = 1'b1;
          state_nxt  = pbs_pkg::S_IDLE;
        end
      end

      pbs_pkg::S_RUN_RD: begin
        state_nxt = pbs_pkg::S_RUN_CALC;
      end

      pbs_pkg::S_RUN_CALC: begin
        clock_nxt    = clock_add;
        status_nxt   = pbs_pkg::ST_DISPATCH;
        id_nxt       = ram_rdata[pbs_pkg::ID_LSB +: pbs_pkg::ID_W];
        burst_nxt    = rd_burst;
        fin_nxt      = pbs_pkg::sat_fin(clock_add);
        avg_wait_nxt = '0;
        avg_turn_nxt = '0;
        avg_resp_nxt = '0;
        last_nxt     = 1'b0;
        if ((idx_r + CW'(1)) == count_r) begin
          // sum_r holds every finish time but the final one
          div_req.start = 1'b1;
          state_nxt     = pbs_pkg::S_DIV_WAIT;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = pbs_pkg::S_RUN_OUT;
        end
      end

      pbs_pkg::S_RUN_OUT: begin
        if (out_fire) begin
          sum_nxt   = sum_turn;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = pbs_pkg::S_RUN_RD;
        end
      end

      // wait and response sums are the same value
      pbs_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          avg_wait_nxt     = pbs_pkg::sat_avg(div_rsp.quotient);
          avg_resp_nxt     = pbs_pkg::sat_avg(div_rsp.quotient);
          div_req.start    = 1'b1;
          div_req.dividend = pbs_pkg::DIV_W'({sum_turn, pbs_pkg::FRAC_W'(0)});
          state_nxt        = pbs_pkg::S_DIV_TURN;
        end
      end

      pbs_pkg::S_DIV_TURN: begin
        if (div_rsp.done) begin
          avg_turn_nxt  = pbs_pkg::sat_avg(div_rsp.quotient);
          last_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          state_nxt     = pbs_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pbs_pkg::S_IDLE;
      end
    endcase

    if (emit_short) begin
      out_valid_nxt = 1'b1;
      status_nxt    = emit_status;
      id_nxt        = '0;
      burst_nxt     = '0;
      fin_nxt       = '0;
      avg_wait_nxt  = '0;
      avg_turn_nxt  = '0;
      avg_resp_nxt  = '0;
      last_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbs_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    clock_r     <= clock_nxt;
    sum_r       <= sum_nxt;
    new_entry_r <= new_entry_nxt;
    status_r    <= status_nxt;
    id_r        <= id_nxt;
    burst_r     <= burst_nxt;
    fin_r       <= fin_nxt;
    avg_wait_r  <= avg_wait_nxt;
    avg_turn_r  <= avg_turn_nxt;
    avg_resp_r  <= avg_resp_nxt;
    last_r      <= last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.out_task_id    = id_r;
  assign out_ch.out_burst      = burst_r;
  assign out_ch.finish_time    = fin_r;
  assign out_ch.avg_wait       = avg_wait_r;
  assign out_ch.avg_turnaround = avg_turn_r;
  assign out_ch.avg_response   = avg_resp_r;
  assign out_ch.last           = last_r;

  `PBS_ASSERT_NEVER(a_count_range, count_r > CW'(pbs_pkg::MAX_TASKS), "task count overflow")
  `PBS_ASSERT(a_div_owner, div_rsp.done |-> (state_r == pbs_pkg::S_DIV_WAIT || state_r == pbs_pkg::S_DIV_TURN), "divider result with no waiter")
  `PBS_ASSERT(a_final_clears, (out_fire && last_r && status_r == pbs_pkg::ST_DISPATCH) |-> count_r == '0, "table not emptied after run")
  `PBS_ASSERT(a_ins_idx, (state_r == pbs_pkg::S_INS_CMP) |-> idx_r != '0, "insert compare at slot zero")

endmodule
